/* design/kcmp_pkg.sv */
// Shared types and constants for the keypad countdown and motor PWM core.
// Used by the front, queue, back and top-level modules; depends on nothing.
package kcmp_pkg;

    localparam logic [7:0] KEY_RELEASED = 8'hFF;
    localparam logic [7:0] KEY_A        = 8'hFE;
    localparam logic [7:0] KEY_B        = 8'hFD;
    localparam logic [7:0] KEY_MODE     = 8'hFB;
    localparam logic [7:0] KEY_PAGE     = 8'hF7;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_A    = 3'd1;
    localparam logic [2:0] EV_B    = 3'd2;
    localparam logic [2:0] EV_MODE = 3'd3;
    localparam logic [2:0] EV_PAGE = 3'd4;

    localparam logic [6:0] MAX_MINUTES = 7'd99;
    localparam logic [5:0] MAX_SECONDS = 6'd59;
    localparam logic [6:0] END_MINUTES = 7'd11;
    localparam logic [5:0] END_SECONDS = 6'd11;
    localparam logic [6:0] DUTY_MAX    = 7'd127;

    localparam logic [1:0] LEVEL_LOW  = 2'd0;
    localparam logic [1:0] LEVEL_MID  = 2'd1;
    localparam logic [1:0] LEVEL_HIGH = 2'd2;

    localparam logic [1:0] MODE_SELECT = 2'd0;
    localparam logic [1:0] MODE_TIME   = 2'd1;
    localparam logic [1:0] MODE_SPEED  = 2'd2;

    localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] CFG_PWM_PERIOD       = 2'd1;
    localparam logic [1:0] CFG_DUTY_STEP        = 2'd2;
    localparam logic [1:0] CFG_DUTY_AT_RESET    = 2'd3;

    localparam logic [5:0] RST_TICKS_PER_SECOND = 6'd50;
    localparam logic [6:0] RST_PWM_PERIOD       = 7'd100;
    localparam logic [5:0] RST_DUTY_STEP        = 6'd30;
    localparam logic [6:0] RST_DUTY_AT_RESET    = 7'd50;

    typedef struct packed {
        logic       slow;
        logic [2:0] key_event;
    } kcmp_item_t;

endpackage

/* design/keypad_countdown_motor_pwm_core.sv */
// Keypad countdown timer with motor PWM drive. One item is accepted in every
// clock cycle while the input is not stalled; each item passes the classifying
// front end into a two-entry queue and then the executing back end, which
// registers its result in the output register. The input stalls only once the
// queue is full behind a stalled result. Configuration writes see cfg_ready
// tied high and must only be issued while the block is idle.
module keypad_countdown_motor_pwm_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] keys,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       pwm_out,
    output logic       buzzer_n,
    output logic       alarm_flag,
    output logic       on_set_page,
    output logic [1:0] key_mode,
    output logic       seconds_selected,
    output logic [6:0] minutes_shown,
    output logic [5:0] seconds_shown,
    output logic [1:0] drive_level,
    output logic [6:0] duty_value,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    kcmp_pkg::kcmp_item_t front_item;
    kcmp_pkg::kcmp_item_t back_item;
    logic                 push;
    logic                 queue_full;
    logic                 pop;
    logic                 queue_valid;

    assign cfg_ready = 1'b1;

    kcmp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .keys       (keys),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    kcmp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item_in   (front_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_valid),
        .item_out  (back_item)
    );

    kcmp_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (queue_valid),
        .q_item           (back_item),
        .q_pop            (pop),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pwm_out          (pwm_out),
        .buzzer_n         (buzzer_n),
        .alarm_flag       (alarm_flag),
        .on_set_page      (on_set_page),
        .key_mode         (key_mode),
        .seconds_selected (seconds_selected),
        .minutes_shown    (minutes_shown),
        .seconds_shown    (seconds_shown),
        .drive_level      (drive_level),
        .duty_value       (duty_value)
    );

endmodule

/* design/kcmp_front.sv */
// Front end: accepts input items, tracks the previous key sample and
// classifies each item into a tick kind and key event. Uses kcmp_pkg.
module kcmp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [7:0]          keys,
    input  logic                queue_full,
    output logic                push,
    output kcmp_pkg::kcmp_item_t item
);

    logic [7:0] prev_keys_reg;
    logic [7:0] prev_keys_next;
    logic [2:0] key_event;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        key_event = kcmp_pkg::EV_NONE;
        if (keys != prev_keys_reg && prev_keys_reg == kcmp_pkg::KEY_RELEASED)
        begin
            unique case (keys)
                kcmp_pkg::KEY_A:    key_event = kcmp_pkg::EV_A;
                kcmp_pkg::KEY_B:    key_event = kcmp_pkg::EV_B;
                kcmp_pkg::KEY_MODE: key_event = kcmp_pkg::EV_MODE;
                kcmp_pkg::KEY_PAGE: key_event = kcmp_pkg::EV_PAGE;
                default:            key_event = kcmp_pkg::EV_NONE;
            endcase
        end
    end

    always_comb
    begin
        item.slow      = cmd;
        item.key_event = cmd ? key_event : kcmp_pkg::EV_NONE;
        prev_keys_next = prev_keys_reg;
        if (push && cmd)
        begin
            prev_keys_next = keys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= kcmp_pkg::KEY_RELEASED;
        end
        else
        begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

/* design/kcmp_queue.sv */
// Two-entry queue of classified items between the front and back ends.
// Uses kcmp_pkg for the item type.
module kcmp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kcmp_pkg::kcmp_item_t item_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output kcmp_pkg::kcmp_item_t item_out
);

    kcmp_pkg::kcmp_item_t slots_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign item_out  = slots_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/kcmp_back.sv */
// Back end: configuration registers, countdown, key actions, PWM and the
// output register. Uses kcmp_pkg for the item type and constants.
module kcmp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  kcmp_pkg::kcmp_item_t q_item,
    output logic                 q_pop,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 pwm_out,
    output logic                 buzzer_n,
    output logic                 alarm_flag,
    output logic                 on_set_page,
    output logic [1:0]           key_mode,
    output logic                 seconds_selected,
    output logic [6:0]           minutes_shown,
    output logic [5:0]           seconds_shown,
    output logic [1:0]           drive_level,
    output logic [6:0]           duty_value
);

    logic [5:0] tps_reg;
    logic [6:0] period_reg;
    logic [5:0] step_reg;

    logic       page_reg,    page_next;
    logic [1:0] mode_reg,    mode_next;
    logic       sel_reg,     sel_next;
    logic [6:0] min_reg,     min_next;
    logic [5:0] sec_reg,     sec_next;
    logic [1:0] level_reg,   level_next;
    logic [6:0] duty_reg,    duty_next;
    logic       alarm_reg,   alarm_next;
    logic [5:0] stc_reg,     stc_next;
    logic [6:0] phase_reg,   phase_next;
    logic       motor_reg,   motor_next;
    logic       pin_reg,     pin_next;
    logic       out_valid_reg, out_valid_next;

    logic [5:0] stc_inc;
    logic [6:0] phase_inc;
    logic [7:0] duty_sum;
    logic [6:0] time_top;
    logic [6:0] time_val;
    logic [6:0] time_new;
    logic       edit_up;

    assign q_pop            = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid        = out_valid_reg;
    assign pwm_out          = pin_reg;
    assign buzzer_n         = !alarm_reg;
    assign alarm_flag       = alarm_reg;
    assign on_set_page      = page_reg;
    assign key_mode         = mode_reg;
    assign seconds_selected = sel_reg;
    assign minutes_shown    = min_reg;
    assign seconds_shown    = sec_reg;
    assign drive_level      = level_reg;
    assign duty_value       = duty_reg;

    assign stc_inc   = stc_reg + 6'd1;
    assign phase_inc = phase_reg + 7'd1;
    assign duty_sum  = {1'b0, duty_reg} + {2'b00, step_reg};
    assign time_top  = sel_reg ? {1'b0, kcmp_pkg::MAX_SECONDS} : kcmp_pkg::MAX_MINUTES;
    assign time_val  = sel_reg ? {1'b0, sec_reg} : min_reg;
    assign edit_up   = (q_item.key_event == kcmp_pkg::EV_A);

    always_comb
    begin
        if (edit_up)
        begin
            time_new = (time_val >= time_top) ? 7'd0 : time_val + 7'd1;
        end
        else
        begin
            time_new = (time_val == 7'd0) ? time_top : time_val - 7'd1;
        end
    end

    always_comb
    begin
        page_next  = page_reg;
        mode_next  = mode_reg;
        sel_next   = sel_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        level_next = level_reg;
        duty_next  = duty_reg;
        alarm_next = alarm_reg;
        stc_next   = stc_reg;
        phase_next = phase_reg;
        motor_next = motor_reg;
        pin_next   = pin_reg;

        if (q_pop)
        begin
            if (q_item.slow)
            begin
                if (!page_reg && !alarm_reg)
                begin
                    stc_next = stc_inc;
                    if (stc_inc >= tps_reg)
                    begin
                        stc_next = 6'd0;
                        if (sec_reg != 6'd0)
                        begin
                            sec_next = sec_reg - 6'd1;
                        end
                        else if (min_reg != 7'd0)
                        begin
                            min_next = min_reg - 7'd1;
                            sec_next = kcmp_pkg::MAX_SECONDS;
                        end
                        else
                        begin
                            min_next   = kcmp_pkg::END_MINUTES;
                            sec_next   = kcmp_pkg::END_SECONDS;
                            alarm_next = 1'b1;
                            motor_next = 1'b0;
                        end
                    end
                end

                unique case (q_item.key_event) inside
                    kcmp_pkg::EV_A, kcmp_pkg::EV_B:
                    begin
                        if (page_reg)
                        begin
                            unique case (mode_reg)
                                kcmp_pkg::MODE_SELECT:
                                begin
                                    sel_next = !sel_reg;
                                end
                                kcmp_pkg::MODE_TIME:
                                begin
                                    if (sel_reg)
                                    begin
                                        sec_next = time_new[5:0];
                                    end
                                    else
                                    begin
                                        min_next = time_new;
                                    end
                                end
                                default:
                                begin
                                    if (edit_up && level_reg != kcmp_pkg::LEVEL_HIGH)
                                    begin
                                        level_next = level_reg + 2'd1;
                                        duty_next  = duty_sum[7] ? kcmp_pkg::DUTY_MAX
                                                                 : duty_sum[6:0];
                                    end
                                    else if (!edit_up && level_reg != kcmp_pkg::LEVEL_LOW)
                                    begin
                                        level_next = level_reg - 2'd1;
                                        duty_next  = (duty_reg > {1'b0, step_reg})
                                                     ? duty_reg - {1'b0, step_reg} : 7'd0;
                                    end
                                end
                            endcase
                        end
                    end
                    kcmp_pkg::EV_MODE:
                    begin
                        mode_next = (mode_reg >= kcmp_pkg::MODE_SPEED)
                                    ? kcmp_pkg::MODE_SELECT : mode_reg + 2'd1;
                    end
                    kcmp_pkg::EV_PAGE:
                    begin
                        page_next  = !page_reg;
                        alarm_next = 1'b0;
                        motor_next = page_reg;
                        stc_next   = 6'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (motor_reg)
            begin
                pin_next   = (phase_reg < duty_reg);
                phase_next = (phase_inc >= period_reg) ? 7'd0 : phase_inc;
            end
            else
            begin
                pin_next = 1'b0;
            end
        end

        if (cfg_valid && cfg_index == kcmp_pkg::CFG_DUTY_AT_RESET)
        begin
            duty_next  = cfg_data;
            level_next = kcmp_pkg::LEVEL_MID;
        end
    end

    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg       <= kcmp_pkg::RST_TICKS_PER_SECOND;
            period_reg    <= kcmp_pkg::RST_PWM_PERIOD;
            step_reg      <= kcmp_pkg::RST_DUTY_STEP;
            page_reg      <= 1'b1;
            mode_reg      <= kcmp_pkg::MODE_SELECT;
            sel_reg       <= 1'b0;
            min_reg       <= 7'd0;
            sec_reg       <= 6'd0;
            level_reg     <= kcmp_pkg::LEVEL_MID;
            duty_reg      <= kcmp_pkg::RST_DUTY_AT_RESET;
            alarm_reg     <= 1'b0;
            stc_reg       <= 6'd0;
            phase_reg     <= 7'd0;
            motor_reg     <= 1'b0;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    kcmp_pkg::CFG_TICKS_PER_SECOND: tps_reg    <= cfg_data[5:0];
                    kcmp_pkg::CFG_PWM_PERIOD:       period_reg <= cfg_data;
                    kcmp_pkg::CFG_DUTY_STEP:        step_reg   <= cfg_data[5:0];
                    default:
                    begin
                    end
                endcase
            end
            page_reg      <= page_next;
            mode_reg      <= mode_next;
            sel_reg       <= sel_next;
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            level_reg     <= level_next;
            duty_reg      <= duty_next;
            alarm_reg     <= alarm_next;
            stc_reg       <= stc_next;
            phase_reg     <= phase_next;
            motor_reg     <= motor_next;
            pin_reg       <= pin_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_alarm_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg |-> !motor_reg)
        else $error("Motor running while the alarm is set.");

    a_set_page_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
        page_reg |-> !motor_reg)
        else $error("Motor running on the setting page.");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (min_reg <= kcmp_pkg::MAX_MINUTES) && (sec_reg <= kcmp_pkg::MAX_SECONDS))
        else $error("Countdown value out of range.");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && !cfg_valid) |=> $stable(duty_reg) && out_valid_reg)
        else $error("Stalled result changed.");
`endif

endmodule

/* sim/testbench.sv */
// Self-checking testbench for keypad_countdown_motor_pwm_core: a scoreboard class predicts
// every result item from the accepted input items and configuration writes.
// Depends on kcmp_pkg and the core; it drives random, handshaked traffic on both channels.
`timescale 1ns / 1ps

typedef struct packed {
    logic       pwm;
    logic       buzzer_n;
    logic       alarm;
    logic       set_page;
    logic [1:0] mode;
    logic       sec_sel;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic [1:0] level;
    logic [6:0] duty;
} panel_t;

class timer_scoreboard;
    bit [5:0] tick_div;
    bit [6:0] period;
    bit [5:0] step;
    bit [6:0] mid_duty;
    bit       setting_page;
    bit [1:0] edit_mode;
    bit       sec_sel;
    bit [6:0] mins;
    bit [5:0] secs;
    bit [1:0] level;
    bit [6:0] duty;
    bit       alarm_on;
    bit [5:0] slow_ticks;
    bit [7:0] last_keys;
    bit [6:0] pwm_count;
    bit       motor_on;
    bit       pin;
    panel_t   expected_panels[$];
    int       failures;

    function new();
        tick_div     = kcmp_pkg::RST_TICKS_PER_SECOND;
        period       = kcmp_pkg::RST_PWM_PERIOD;
        step         = kcmp_pkg::RST_DUTY_STEP;
        mid_duty     = kcmp_pkg::RST_DUTY_AT_RESET;
        setting_page = 1'b1;
        edit_mode    = kcmp_pkg::MODE_SELECT;
        sec_sel      = 1'b0;
        mins         = '0;
        secs         = '0;
        level        = kcmp_pkg::LEVEL_MID;
        duty         = kcmp_pkg::RST_DUTY_AT_RESET;
        alarm_on     = 1'b0;
        slow_ticks   = '0;
        last_keys    = kcmp_pkg::KEY_RELEASED;
        pwm_count    = '0;
        motor_on     = 1'b0;
        pin          = 1'b0;
        failures     = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [6:0] data);
        case (idx)
            kcmp_pkg::CFG_TICKS_PER_SECOND: tick_div = data[5:0];
            kcmp_pkg::CFG_PWM_PERIOD:       period = data;
            kcmp_pkg::CFG_DUTY_STEP:        step = data[5:0];
            kcmp_pkg::CFG_DUTY_AT_RESET:
            begin
                mid_duty = data;
                duty     = data;
                level    = kcmp_pkg::LEVEL_MID;
            end
            default: ;
        endcase
    endfunction

    function void count_second();
        slow_ticks = slow_ticks + 6'd1;
        if (slow_ticks < tick_div)
            return;
        slow_ticks = '0;
        if (secs != 0)
        begin
            secs = secs - 6'd1;
            return;
        end
        if (mins != 0)
        begin
            mins = mins - 7'd1;
            secs = kcmp_pkg::MAX_SECONDS;
            return;
        end
        mins     = kcmp_pkg::END_MINUTES;
        secs     = kcmp_pkg::END_SECONDS;
        alarm_on = 1'b1;
        motor_on = 1'b0;
    endfunction

    function void press_edit(bit up);
        int sum;
        if (!setting_page)
            return;
        if (edit_mode == kcmp_pkg::MODE_SELECT)
            sec_sel = ~sec_sel;
        else if (edit_mode == kcmp_pkg::MODE_TIME)
        begin
            if (sec_sel)
            begin
                if (up)
                    secs = (secs >= kcmp_pkg::MAX_SECONDS) ? 6'd0 : secs + 6'd1;
                else
                    secs = (secs == 0) ? kcmp_pkg::MAX_SECONDS : secs - 6'd1;
            end
            else
            begin
                if (up)
                    mins = (mins >= kcmp_pkg::MAX_MINUTES) ? 7'd0 : mins + 7'd1;
                else
                    mins = (mins == 0) ? kcmp_pkg::MAX_MINUTES : mins - 7'd1;
            end
        end
        else if (up)
        begin
            if (level != kcmp_pkg::LEVEL_HIGH)
            begin
                level = level + 2'd1;
                sum   = int'(duty) + int'(step);
                duty  = (sum > int'(kcmp_pkg::DUTY_MAX)) ? kcmp_pkg::DUTY_MAX : 7'(sum);
            end
        end
        else if (level != kcmp_pkg::LEVEL_LOW)
        begin
            level = level - 2'd1;
            duty  = (duty > step) ? duty - 7'(step) : 7'd0;
        end
    endfunction

    function void take_port(bit [7:0] k);
        if (k == last_keys)
            return;
        if (last_keys == kcmp_pkg::KEY_RELEASED)
        begin
            case (k)
                kcmp_pkg::KEY_A:    press_edit(1'b1);
                kcmp_pkg::KEY_B:    press_edit(1'b0);
                kcmp_pkg::KEY_MODE:
                    edit_mode = (edit_mode >= kcmp_pkg::MODE_SPEED) ? kcmp_pkg::MODE_SELECT
                                                                    : edit_mode + 2'd1;
                kcmp_pkg::KEY_PAGE:
                begin
                    setting_page = ~setting_page;
                    alarm_on     = 1'b0;
                    motor_on     = ~setting_page;
                    slow_ticks   = '0;
                end
                default: ;
            endcase
        end
        last_keys = k;
    endfunction

    function void note_item(bit c, bit [7:0] k);
        panel_t p;
        if (c)
        begin
            if (!setting_page && !alarm_on)
                count_second();
            take_port(k);
        end
        else if (motor_on)
        begin
            pin       = (pwm_count < duty);
            pwm_count = pwm_count + 7'd1;
            if (pwm_count >= period)
                pwm_count = '0;
        end
        else
            pin = 1'b0;
        p.pwm      = pin;
        p.buzzer_n = ~alarm_on;
        p.alarm    = alarm_on;
        p.set_page = setting_page;
        p.mode     = edit_mode;
        p.sec_sel  = sec_sel;
        p.minutes  = mins;
        p.seconds  = secs;
        p.level    = level;
        p.duty     = duty;
        expected_panels.push_back(p);
    endfunction

    function string panel_text(panel_t p);
        return $sformatf({"pwm=%b buz_n=%b alarm=%b page=%b mode=%0d sel=%b ",
                          "%0d:%0d lvl=%0d duty=%0d"},
                         p.pwm, p.buzzer_n, p.alarm, p.set_page, p.mode, p.sec_sel,
                         p.minutes, p.seconds, p.level, p.duty);
    endfunction

    function void check_panel(panel_t got);
        panel_t want;
        if (expected_panels.size() == 0)
        begin
            failures++;
            if (failures <= 10)
                $display("Unexpected result item: %s", panel_text(got));
            return;
        end
        want = expected_panels.pop_front();
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("Result mismatch\n  expected %s\n  actual   %s",
                         panel_text(want), panel_text(got));
        end
    endfunction
endclass

module testbench;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS      = 200;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd;
    logic [7:0] keys;
    logic       out_valid;
    logic       out_stall;
    logic       pwm_out;
    logic       buzzer_n;
    logic       alarm_flag;
    logic       on_set_page;
    logic [1:0] key_mode;
    logic       seconds_selected;
    logic [6:0] minutes_shown;
    logic [5:0] seconds_shown;
    logic [1:0] drive_level;
    logic [6:0] duty_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    timer_scoreboard sb;
    int              items_sent;
    int              burst_left;
    bit              hold_request;

    keypad_countdown_motor_pwm_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .keys             (keys),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pwm_out          (pwm_out),
        .buzzer_n         (buzzer_n),
        .alarm_flag       (alarm_flag),
        .on_set_page      (on_set_page),
        .key_mode         (key_mode),
        .seconds_selected (seconds_selected),
        .minutes_shown    (minutes_shown),
        .seconds_shown    (seconds_shown),
        .drive_level      (drive_level),
        .duty_value       (duty_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        panel_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.pwm      = pwm_out;
            got.buzzer_n = buzzer_n;
            got.alarm    = alarm_flag;
            got.set_page = on_set_page;
            got.mode     = key_mode;
            got.sec_sel  = seconds_selected;
            got.minutes  = minutes_shown;
            got.seconds  = seconds_shown;
            got.level    = drive_level;
            got.duty     = duty_value;
            sb.check_panel(got);
        end
    end

    initial
    begin : receiver
        int           seg_len;
        stall_style_t style;
        bit           stall_bit;
        out_stall <= 1'b0;
        stall_bit = 1'b0;
        forever
        begin
            seg_len = $urandom_range(4, 60);
            style   = stall_style_t'($urandom_range(0, 3));
            repeat (seg_len)
            begin
                @(posedge clk);
                case (style)
                    STALL_NONE:  stall_bit = 1'b0;
                    STALL_LIGHT: stall_bit = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: stall_bit = ($urandom_range(0, 3) != 0);
                    default:     stall_bit = ~stall_bit;
                endcase
                out_stall <= stall_bit;
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (LONG_HOLD_CYCLES)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    task automatic offer(input logic c, input logic [7:0] k);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(10, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                cmd      <= 1'($urandom_range(0, 1));
                keys     <= 8'($urandom_range(0, 255));
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd      <= c;
        keys     <= k;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_item(c, k);
        items_sent++;
    endtask

    task automatic press_key(input logic [7:0] k);
        offer(1'b1, k);
        repeat ($urandom_range(0, 2))
            offer(1'b0, 8'($urandom_range(0, 255)));
        offer(1'b1, kcmp_pkg::KEY_RELEASED);
    endtask

    task automatic seek_mode(input logic [1:0] m);
        while (sb.edit_mode != m)
            press_key(kcmp_pkg::KEY_MODE);
    endtask

    task automatic move_field(input int target);
        int  top;
        int  cur;
        int  up_dist;
        int  down_dist;
        logic [7:0] k;
        top       = sb.sec_sel ? int'(kcmp_pkg::MAX_SECONDS) : int'(kcmp_pkg::MAX_MINUTES);
        cur       = sb.sec_sel ? int'(sb.secs) : int'(sb.mins);
        up_dist   = (target - cur + top + 1) % (top + 1);
        down_dist = (cur - target + top + 1) % (top + 1);
        k         = (up_dist < down_dist) ? kcmp_pkg::KEY_A : kcmp_pkg::KEY_B;
        while ((sb.sec_sel ? int'(sb.secs) : int'(sb.mins)) != target)
            press_key(k);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.apply_reg(idx, data);
    endtask

    task automatic configure(input logic [6:0] tps, input logic [6:0] per,
                             input logic [6:0] stp, input logic [6:0] mid);
        write_reg(kcmp_pkg::CFG_TICKS_PER_SECOND, tps);
        write_reg(kcmp_pkg::CFG_PWM_PERIOD, per);
        write_reg(kcmp_pkg::CFG_DUTY_STEP, stp);
        write_reg(kcmp_pkg::CFG_DUTY_AT_RESET, mid);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (sb.expected_panels.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int         target;
        int         pick;
        int         run_len;
        logic [7:0] k;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 5)
                    k = kcmp_pkg::KEY_A;
                else if (pick < 10)
                    k = kcmp_pkg::KEY_B;
                else if (pick < 14)
                    k = kcmp_pkg::KEY_MODE;
                else if (pick < 16)
                    k = kcmp_pkg::KEY_PAGE;
                else if (pick < 18)
                    k = 8'($urandom_range(0, 255));
                else
                    k = kcmp_pkg::KEY_RELEASED;
                offer(1'b1, k);
                repeat ($urandom_range(0, 4))
                    offer(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 19) < 17)
                    offer(1'b1, kcmp_pkg::KEY_RELEASED);
            end
            else if (pick <= 6)
            begin
                repeat ($urandom_range(1, 30))
                    offer(1'b0, 8'($urandom_range(0, 255)));
            end
            else if (pick == 7)
            begin
                offer(1'b1, kcmp_pkg::KEY_RELEASED);
                if (!sb.setting_page)
                    press_key(kcmp_pkg::KEY_PAGE);
                seek_mode(kcmp_pkg::MODE_SELECT);
                if (sb.sec_sel)
                    press_key(kcmp_pkg::KEY_A);
                seek_mode(kcmp_pkg::MODE_TIME);
                move_field(0);
                seek_mode(kcmp_pkg::MODE_SELECT);
                press_key(kcmp_pkg::KEY_A);
                seek_mode(kcmp_pkg::MODE_TIME);
                move_field(int'($urandom_range(0, 3)));
                press_key(kcmp_pkg::KEY_PAGE);
                run_len = int'(sb.tick_div) * (int'(sb.secs) + 1) + 2;
                if (run_len > 150)
                    run_len = 150;
                repeat (run_len)
                begin
                    offer(1'b1, kcmp_pkg::KEY_RELEASED);
                    if ($urandom_range(0, 2) == 0)
                        offer(1'b0, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) == 0)
                        offer(1'b1, ($urandom_range(0, 1) == 0) ? kcmp_pkg::KEY_A
                                                                : kcmp_pkg::KEY_B);
                end
            end
            else if (pick == 8)
                press_key(kcmp_pkg::KEY_PAGE);
            else
            begin
                repeat ($urandom_range(1, 5))
                    offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        items_sent   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= 1'b0;
        keys      <= kcmp_pkg::KEY_RELEASED;
        cfg_valid <= 1'b0;
        cfg_index <= kcmp_pkg::CFG_TICKS_PER_SECOND;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(7'd1, 7'd4, {1'b0, kcmp_pkg::RST_DUTY_STEP}, kcmp_pkg::RST_DUTY_AT_RESET);
        offer(1'b0, 8'h00);
        press_key(kcmp_pkg::KEY_A);
        press_key(kcmp_pkg::KEY_MODE);
        press_key(kcmp_pkg::KEY_B);
        press_key(kcmp_pkg::KEY_A);
        offer(1'b1, 8'h00);
        offer(1'b1, kcmp_pkg::KEY_A);
        offer(1'b1, kcmp_pkg::KEY_RELEASED);
        press_key(kcmp_pkg::KEY_MODE);
        press_key(kcmp_pkg::KEY_A);
        press_key(kcmp_pkg::KEY_A);
        press_key(kcmp_pkg::KEY_B);
        press_key(kcmp_pkg::KEY_MODE);
        press_key(kcmp_pkg::KEY_PAGE);
        offer(1'b0, 8'hFF);
        offer(1'b0, 8'h5A);
        settle();

        configure({1'b0, kcmp_pkg::RST_TICKS_PER_SECOND}, kcmp_pkg::RST_PWM_PERIOD,
                  {1'b0, kcmp_pkg::RST_DUTY_STEP}, kcmp_pkg::RST_DUTY_AT_RESET);
        random_phase(PHASE_ITEMS);
        settle();
        configure(7'd1, 7'd1, 7'd40, kcmp_pkg::DUTY_MAX);
        hold_request = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();
        configure(7'd63, 7'd127, 7'd0, 7'd0);
        random_phase(PHASE_ITEMS);
        settle();
        configure(7'd0, 7'd0, 7'd40, 7'd0);
        random_phase(PHASE_ITEMS);
        settle();
        configure(7'($urandom_range(1, 63)), 7'($urandom_range(1, 127)),
                  7'($urandom_range(0, 40)), 7'($urandom_range(0, 127)));
        random_phase(PHASE_ITEMS);
        settle();
        configure(7'($urandom_range(1, 4)), 7'($urandom_range(1, 20)),
                  7'($urandom_range(0, 40)), 7'($urandom_range(0, 127)));
        random_phase(PHASE_ITEMS);
        settle();

        if (sb.failures == 0 && sb.expected_panels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
design/kcmp_pkg.sv
design/kcmp_front.sv
design/kcmp_queue.sv
design/kcmp_back.sv
design/keypad_countdown_motor_pwm_core.sv
sim/testbench.sv
